// ===== src/video_capture_address_generator_defines.svh =====
// Assertion macros used by the port-level checker of the capture address generator.
`ifndef VIDEO_CAPTURE_ADDRESS_GENERATOR_DEFINES_SVH
`define VIDEO_CAPTURE_ADDRESS_GENERATOR_DEFINES_SVH

// Check on every clock edge while reset is low.
`define VCAG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define VCAG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/vcag_pkg.sv =====
// Types and constants shared by the capture address generator modules.
package vcag_pkg;

   localparam int CNT_W     = 12;
   localparam int DIM_W     = 12;
   localparam int ADDR_W    = 22;
   localparam int COLOUR_W  = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;
   localparam int ROT_W     = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_MODE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTICAL_FLIP = 2'd3;

   // rotation codes
   localparam logic [ROT_W-1:0] ROT_NONE  = 2'd0;
   localparam logic [ROT_W-1:0] ROT_LEFT  = 2'd1;
   localparam logic [ROT_W-1:0] ROT_RIGHT = 2'd2;

   localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 12'd512;

   typedef struct packed {
      logic                hblank;
      logic                vblank;
      logic                hsync;
      logic                vsync;
      logic [COLOUR_W-1:0] colour;
   } req_item_type;

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic [ROT_W-1:0] rotate_mode;
      logic             vertical_flip;
   } cfg_type;

   // raster position handed from the tracker to the address stage
   typedef struct packed {
      logic             display;
      logic             frame_start;
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] stride;
   } pos_type;

   typedef struct packed {
      logic                write_enable;
      logic [ADDR_W-1:0]   write_address;
      logic [COLOUR_W-1:0] write_data;
      logic                frame_start;
   } rsp_item_type;

endpackage

// ===== src/vcag_if.sv =====
// Valid/ready channel interfaces for pixel samples and frame-buffer writes.
interface vcag_req_if;
   import vcag_pkg::*;
   logic                valid;
   logic                ready;
   logic                hblank;
   logic                vblank;
   logic                hsync;
   logic                vsync;
   logic [COLOUR_W-1:0] colour;

   modport source (output valid, hblank, vblank, hsync, vsync, colour, input ready);
   modport sink   (input valid, hblank, vblank, hsync, vsync, colour, output ready);
endinterface

interface vcag_rsp_if;
   import vcag_pkg::*;
   logic                valid;
   logic                ready;
   logic                write_enable;
   logic [ADDR_W-1:0]   write_address;
   logic [COLOUR_W-1:0] write_data;
   logic                frame_start;

   modport source (output valid, write_enable, write_address, write_data, frame_start,
                   input ready);
   modport sink   (input valid, write_enable, write_address, write_data, frame_start,
                   output ready);
endinterface

// ===== src/vcag_raster.sv =====
// Raster tracker: pixel/line counters, sync edge detect and rotated, clamped position.
module vcag_raster #(
   parameter int MAX_DIM = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  vcag_pkg::req_item_type item,
   input  vcag_pkg::cfg_type      cfg,
   output vcag_pkg::pos_type      pos
);
   import vcag_pkg::*;

   localparam int                SPOS_W    = DIM_W + 3;
   localparam logic [DIM_W:0]    DIM_LIMIT = (DIM_W + 1)'(MAX_DIM);
   localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

   logic [CNT_W-1:0] pixel_count_ff, pixel_count_in;
   logic [CNT_W-1:0] line_count_ff, line_count_in;
   logic             prev_hsync_ff, prev_vsync_ff;
   logic             display, frame_start;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic signed [SPOS_W-1:0] px, ln, w_s, h_s, x_r, y_r, y_f, x_c, y_c;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if ({1'b0, v} > DIM_LIMIT) begin
         r = DIM_W'(DIM_LIMIT);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
   endfunction

   assign display = !item.hblank && !item.vblank;

   // counter update in the order: hsync edge or pixel step, then vsync edge
   always_comb begin
      pixel_count_in = pixel_count_ff;
      line_count_in  = line_count_ff;
      frame_start    = 1'b0;
      if (!item.vblank) begin
         if (prev_hsync_ff && !item.hsync) begin
            line_count_in  = sat_inc(line_count_ff);
            pixel_count_in = '0;
         end else if (display) begin
            pixel_count_in = sat_inc(pixel_count_ff);
         end
      end
      if (prev_vsync_ff && !item.vsync) begin
         frame_start   = 1'b1;
         line_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= '0;
         line_count_ff  <= '0;
         prev_hsync_ff  <= 1'b0;
         prev_vsync_ff  <= 1'b0;
      end else if (advance) begin
         pixel_count_ff <= pixel_count_in;
         line_count_ff  <= line_count_in;
         prev_hsync_ff  <= item.hsync;
         prev_vsync_ff  <= item.vsync;
      end
   end

   assign w_eff = eff_dim(cfg.frame_width);
   assign h_eff = eff_dim(cfg.frame_height);
   assign w_s   = $signed({3'b000, w_eff});
   assign h_s   = $signed({3'b000, h_eff});
   assign px    = $signed({3'b000, pixel_count_in}) - SPOS_W'(1);
   assign ln    = $signed({3'b000, line_count_in}) - SPOS_W'(1);

   always_comb begin
      case (cfg.rotate_mode)
         ROT_LEFT: begin
            y_r = h_s - px;
            x_r = ln;
         end
         ROT_RIGHT: begin
            y_r = px;
            x_r = w_s - ln;
         end
         default: begin
            y_r = ln;
            x_r = px;
         end
      endcase
   end

   assign y_f = cfg.vertical_flip ? h_s - y_r : y_r;

   // clamp into the frame
   always_comb begin
      if (x_r < 0) begin
         x_c = '0;
      end else if (x_r > w_s - SPOS_W'(1)) begin
         x_c = w_s - SPOS_W'(1);
      end else begin
         x_c = x_r;
      end
      if (y_f < 0) begin
         y_c = '0;
      end else if (y_f > h_s - SPOS_W'(1)) begin
         y_c = h_s - SPOS_W'(1);
      end else begin
         y_c = y_f;
      end
   end

   assign pos.display     = display;
   assign pos.frame_start = frame_start;
   assign pos.x           = x_c[DIM_W-1:0];
   assign pos.y           = y_c[DIM_W-1:0];
   assign pos.stride      = w_eff;

endmodule

// ===== src/vcag_address.sv =====
// Address stage: row-major frame-buffer address and blanking of the write fields.
module vcag_address (
   input  logic [vcag_pkg::COLOUR_W-1:0] colour,
   input  vcag_pkg::pos_type             pos,
   output vcag_pkg::rsp_item_type        rsp
);
   import vcag_pkg::*;

   localparam int PROD_W = 2 * DIM_W + 1;

   logic [PROD_W-1:0] addr_full;

   assign addr_full = PROD_W'(pos.y * pos.stride) + PROD_W'(pos.x);

   // blanked samples write nothing and carry zero payload
   assign rsp.write_enable  = pos.display;
   assign rsp.write_address = pos.display ? addr_full[ADDR_W-1:0] : '0;
   assign rsp.write_data    = pos.display ? colour : '0;
   assign rsp.frame_start   = pos.frame_start;

endmodule

// ===== src/video_capture_address_generator.sv =====
// Top level of the video capture write-address generator.
// One pixel sample is taken per clock while req_if.ready is high and gives exactly one result: a frame-buffer write
// (enable, address y*width+x, colour) plus a frame-start flag on a falling vsync.
// The sample lands in an input register, then the raster tracker
// and the address stage (one 12x12 multiply and add) fill the result register.
// Throughput is one item per cycle while rsp_if.ready stays high; the rate is set by that single-pass stage.
// req_if.ready drops only when both registers hold an item and rsp_if.ready is low.
// Configuration writes take effect at once and must land while the block is idle.
// Blanked samples return write_enable low with zero address and data.
module video_capture_address_generator #(
   parameter int MAX_DIM = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   vcag_req_if.sink                         req_if,
   vcag_rsp_if.source                       rsp_if,
   input  logic                             csr_write_enable,
   input  logic [vcag_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vcag_pkg::CSR_DAT_W-1:0]   csr_write_data
);
   import vcag_pkg::*;

   cfg_type       cfg_ff;
   req_item_type  s1_item_ff;
   logic          s1_valid_ff;
   rsp_item_type  rsp_ff;
   rsp_item_type  rsp_in;
   logic          rsp_valid_ff;
   logic          advance;
   logic          fire;
   pos_type       pos;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= FRAME_DIM_RESET;
         cfg_ff.frame_height  <= FRAME_DIM_RESET;
         cfg_ff.rotate_mode   <= ROT_NONE;
         cfg_ff.vertical_flip <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   cfg_ff.frame_width   <= csr_write_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_ff.frame_height  <= csr_write_data[DIM_W-1:0];
            CSR_ROTATE_MODE:   cfg_ff.rotate_mode   <= csr_write_data[ROT_W-1:0];
            CSR_VERTICAL_FLIP: cfg_ff.vertical_flip <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // advance the pipe whenever the result register is free or being drained
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign fire         = s1_valid_ff && advance;
   assign req_if.ready = !s1_valid_ff || advance;

   // input register: hold a sample until the next stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_item_ff.hblank <= req_if.hblank;
         s1_item_ff.vblank <= req_if.vblank;
         s1_item_ff.hsync  <= req_if.hsync;
         s1_item_ff.vsync  <= req_if.vsync;
         s1_item_ff.colour <= req_if.colour;
      end
   end

   // raster state moves only when the sample transfers into the result register
   vcag_raster #(
      .MAX_DIM (MAX_DIM)
   ) u_raster (
      .clock   (clock),
      .reset   (reset),
      .advance (fire),
      .item    (s1_item_ff),
      .cfg     (cfg_ff),
      .pos     (pos)
   );

   vcag_address u_address (
      .colour (s1_item_ff.colour),
      .pos    (pos),
      .rsp    (rsp_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.write_enable  = rsp_ff.write_enable;
   assign rsp_if.write_address = rsp_ff.write_address;
   assign rsp_if.write_data    = rsp_ff.write_data;
   assign rsp_if.frame_start   = rsp_ff.frame_start;

endmodule

// ===== src/vcag_checker.sv =====
// Port-level checks for the capture address generator, bound to its top level.
`include "video_capture_address_generator_defines.svh"

module vcag_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_write_enable,
   input logic [vcag_pkg::ADDR_W-1:0]    rsp_write_address,
   input logic [vcag_pkg::COLOUR_W-1:0]  rsp_write_data,
   input logic                           rsp_frame_start
);
   import vcag_pkg::*;

   `VCAG_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

   `VCAG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_enable) && $stable(rsp_write_address) && $stable(rsp_write_data) && $stable(rsp_frame_start), "stalled result changed")

   `VCAG_ASSERT(a_blank_zero, clock, reset, rsp_valid && !rsp_write_enable |-> rsp_write_address == '0 && rsp_write_data == '0, "blanked result carries payload")

   `VCAG_ASSERT(a_latency, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "result without a transfer two cycles earlier")

endmodule

bind video_capture_address_generator vcag_checker u_vcag_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_write_enable  (rsp_if.write_enable),
   .rsp_write_address (rsp_if.write_address),
   .rsp_write_data    (rsp_if.write_data),
   .rsp_frame_start   (rsp_if.frame_start)
);

// ===== verif/video_capture_address_generator_tb.sv =====
// Self-checking testbench for the video capture write-address generator.
`timescale 1ns / 100ps

module video_capture_address_generator_tb;
   import vcag_pkg::*;

   localparam int MAX_DIM          = 2048;
   localparam int STALL_PCT        = 14;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int PHASE_SAMPLES    = 125;
   localparam int RANDOM_PHASES    = 6;
   localparam int LONG_LINE_PIXELS = 100;
   localparam int HSYNC_PULSES     = 40;

   // rotate code with no meaning of its own, behaves as no rotation
   localparam logic [ROT_W-1:0] ROT_UNUSED = 2'd3;

   // Tracks the raster position like the block does and queues the frame-buffer
   // write that every accepted pixel sample should produce.
   class frame_write_tracker;
      cfg_type          cfg;
      logic [CNT_W-1:0] pixel_count;
      logic [CNT_W-1:0] line_count;
      logic             hsync_seen;
      logic             vsync_seen;
      rsp_item_type     pending_writes[$];
      int               failures;

      function new();
         cfg.frame_width   = FRAME_DIM_RESET;
         cfg.frame_height  = FRAME_DIM_RESET;
         cfg.rotate_mode   = ROT_NONE;
         cfg.vertical_flip = 1'b0;
         pixel_count       = '0;
         line_count        = '0;
         hsync_seen        = 1'b0;
         vsync_seen        = 1'b0;
         failures          = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
         case (idx)
            CSR_FRAME_WIDTH:   cfg.frame_width   = value;
            CSR_FRAME_HEIGHT:  cfg.frame_height  = value;
            CSR_ROTATE_MODE:   cfg.rotate_mode   = value[ROT_W-1:0];
            CSR_VERTICAL_FLIP: cfg.vertical_flip = value[0];
            default: ;
         endcase
      endfunction

      // saturating counter step
      function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
         return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
      endfunction

      // zero acts as one, oversize acts as the largest frame
      function int span(logic [DIM_W-1:0] v);
         if (v == '0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return int'(v);
      endfunction

      function rsp_item_type predict_write(req_item_type s);
         rsp_item_type r;
         logic         active;
         int           w, h, px, ln, x, y, addr;
         r      = '0;
         active = !s.hblank && !s.vblank;
         if (!s.vblank) begin
            if (hsync_seen && !s.hsync) begin
               line_count  = bump(line_count);
               pixel_count = '0;
            end else if (active) begin
               pixel_count = bump(pixel_count);
            end
         end
         if (vsync_seen && !s.vsync) begin
            r.frame_start = 1'b1;
            line_count    = '0;
         end
         if (active) begin
            w  = span(cfg.frame_width);
            h  = span(cfg.frame_height);
            px = int'(pixel_count) - 1;
            ln = int'(line_count) - 1;
            x  = px;
            y  = ln;
            case (cfg.rotate_mode)
               ROT_LEFT: begin
                  y = h - px;
                  x = ln;
               end
               ROT_RIGHT: begin
                  y = px;
                  x = w - ln;
               end
               default: ;
            endcase
            if (cfg.vertical_flip) y = h - y;
            if (x < 0) x = 0;
            if (x > w - 1) x = w - 1;
            if (y < 0) y = 0;
            if (y > h - 1) y = h - 1;
            addr            = y * w + x;
            r.write_enable  = 1'b1;
            r.write_address = addr[ADDR_W-1:0];
            r.write_data    = s.colour;
         end
         hsync_seen = s.hsync;
         vsync_seen = s.vsync;
         return r;
      endfunction

      function void note_sample(req_item_type s);
         pending_writes.push_back(predict_write(s));
      endfunction

      function void check_write(rsp_item_type got);
         rsp_item_type want;
         if (pending_writes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected write: we=%0b addr=%06h data=%08h fs=%0b",
                        got.write_enable, got.write_address, got.write_data,
                        got.frame_start);
            return;
         end
         want = pending_writes.pop_front();
         if (got.write_enable !== want.write_enable ||
             got.write_address !== want.write_address ||
             got.write_data !== want.write_data || got.frame_start !== want.frame_start) begin
            failures++;
            if (failures <= 10)
               $display({"write mismatch: expected we=%0b addr=%06h data=%08h fs=%0b,",
                         " got we=%0b addr=%06h data=%08h fs=%0b"},
                        want.write_enable, want.write_address, want.write_data,
                        want.frame_start, got.write_enable, got.write_address,
                        got.write_data, got.frame_start);
         end
      endfunction

      function int pending();
         return pending_writes.size();
      endfunction

      // count writes that never showed up as failures too
      function int final_count();
         if (pending_writes.size() != 0)
            $display("%0d expected writes never arrived", pending_writes.size());
         return failures + pending_writes.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_write_data;

   // cleared for one phase to get a stretch with no idle cycles on either side
   bit idle_on = 1'b1;
   int samples_sent = 0;
   int quiet_cycles = 0;

   vcag_req_if req_if ();
   vcag_rsp_if rsp_if ();

   frame_write_tracker tracker = new();

   video_capture_address_generator #(
      .MAX_DIM (MAX_DIM)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Drive the result side's ready at the falling edge; stall at random.
   always @(negedge clock) begin
      rsp_if.ready <= !idle_on || ($urandom_range(99) >= STALL_PCT);
   end

   // Check every write transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.check_write(rsp_item_type'{rsp_if.write_enable, rsp_if.write_address,
                                            rsp_if.write_data, rsp_if.frame_start});
   end

   // Watchdog: stop the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_item_type pixel_sample(bit hb, bit vb, bit hs, bit vs,
                                                 logic [COLOUR_W-1:0] col);
      req_item_type s;
      s.hblank = hb;
      s.vblank = vb;
      s.hsync  = hs;
      s.vsync  = vs;
      s.colour = col;
      return s;
   endfunction

   // Pick a frame dimension: mostly small, sometimes the edges of the range.
   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(7))
         0:       return '0;
         1:       return DIM_W'(1);
         2:       return DIM_W'(MAX_DIM);
         3:       return DIM_W'($urandom_range(MAX_DIM + 1, 4095));
         default: return DIM_W'($urandom_range(2, 48));
      endcase
   endfunction

   // Offer one sample, idle first at random, and hold it until the transfer.
   // Called and returns at a falling edge.
   task automatic send_sample(input req_item_type s);
      while (idle_on && $urandom_range(99) < STALL_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.hblank <= s.hblank;
      req_if.vblank <= s.vblank;
      req_if.hsync  <= s.hsync;
      req_if.vsync  <= s.vsync;
      req_if.colour <= s.colour;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_sample(s);
      samples_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every expected write has come back, then let
   // the two pipeline stages settle.
   task automatic drain_writes();
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write all four registers back to back while the block is idle. Put junk in
   // the unused upper bits of the narrow registers.
   task automatic apply_setting(input logic [CSR_DAT_W-1:0] w, input logic [CSR_DAT_W-1:0] h,
                                input logic [ROT_W-1:0] rot, input logic flip);
      logic [CSR_IDX_W-1:0] regs [4];
      logic [CSR_DAT_W-1:0] value [4];
      logic [CSR_DAT_W-1:0] junk;
      regs[0]  = CSR_FRAME_WIDTH;
      regs[1]  = CSR_FRAME_HEIGHT;
      regs[2]  = CSR_ROTATE_MODE;
      regs[3]  = CSR_VERTICAL_FLIP;
      junk     = CSR_DAT_W'($urandom);
      value[0] = w;
      value[1] = h;
      value[2] = {junk[CSR_DAT_W-1:ROT_W], rot};
      value[3] = {junk[CSR_DAT_W-1:1], flip};
      drain_writes();
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= regs[i];
         csr_write_data   <= value[i];
         @(posedge clock);
         tracker.write_register(regs[i], value[i]);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // One well-formed frame: vertical blanking ending in a vsync fall, then lines
   // of horizontal blanking with an hsync pulse followed by active pixels.
   task automatic send_frame(input int lines, input int pixels);
      repeat ($urandom_range(1, 3))
         send_sample(pixel_sample(1'b1, 1'b1, 1'b0, 1'b1, $urandom));
      send_sample(pixel_sample(1'b1, 1'b1, 1'b0, 1'b0, $urandom));
      repeat (lines) begin
         repeat ($urandom_range(1, 2))
            send_sample(pixel_sample(1'b1, 1'b0, 1'b1, 1'b0, $urandom));
         send_sample(pixel_sample(1'b1, 1'b0, 1'b0, 1'b0, $urandom));
         repeat ($urandom_range(0, 2))
            send_sample(pixel_sample(1'b1, 1'b0, 1'b0, 1'b0, $urandom));
         repeat ($urandom_range(1, pixels))
            send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, $urandom));
      end
   endtask

   // One configuration phase: mostly frames with random content, some noise,
   // and now and then a pause until the pipeline is empty.
   task automatic run_phase(input logic [CSR_DAT_W-1:0] w, input logic [CSR_DAT_W-1:0] h,
                            input logic [ROT_W-1:0] rot, input logic flip);
      int first;
      apply_setting(w, h, rot, flip);
      first = samples_sent;
      while (samples_sent - first < PHASE_SAMPLES) begin
         if ($urandom_range(99) < 80) begin
            send_frame($urandom_range(1, 12), $urandom_range(1, 30));
         end else begin
            repeat ($urandom_range(1, 8))
               send_sample(pixel_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                        1'($urandom_range(1)), 1'($urandom_range(1)),
                                        $urandom));
         end
         if ($urandom_range(7) == 0) drain_writes();
      end
   endtask

   // Drive one long line and a run of hsync pulses on the largest frame, then
   // continue that line under right and left rotation.
   task automatic run_long_line();
      apply_setting(12'd4095, 12'd4095, ROT_NONE, 1'b0);
      send_sample(pixel_sample(1'b1, 1'b1, 1'b0, 1'b1, $urandom));
      send_sample(pixel_sample(1'b1, 1'b1, 1'b0, 1'b0, $urandom));
      repeat (LONG_LINE_PIXELS) send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, $urandom));
      repeat (HSYNC_PULSES) begin
         send_sample(pixel_sample(1'b1, 1'b0, 1'b1, 1'b0, $urandom));
         send_sample(pixel_sample(1'b1, 1'b0, 1'b0, 1'b0, $urandom));
      end
      repeat (3) send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, $urandom));
      apply_setting(12'd2048, 12'd2048, ROT_RIGHT, 1'b1);
      repeat (3) send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, $urandom));
      apply_setting(12'd5, 12'd3, ROT_LEFT, 1'b0);
      repeat (3) send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, $urandom));
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FRAME_WIDTH;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.hblank    = 1'b0;
      req_if.vblank    = 1'b0;
      req_if.hsync     = 1'b0;
      req_if.vsync     = 1'b0;
      req_if.colour    = '0;
      rsp_if.ready     = 1'b0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed samples under the reset configuration: colour extremes, each
      // blanking combination, sync falls inside and outside vertical blanking,
      // and hsync and vsync falling together.
      send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000));
      send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF));
      send_sample(pixel_sample(1'b1, 1'b0, 1'b0, 1'b0, 32'hA5A5_A5A5));
      send_sample(pixel_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'h5A5A_5A5A));
      send_sample(pixel_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
      send_sample(pixel_sample(1'b1, 1'b1, 1'b0, 1'b1, $urandom));
      send_sample(pixel_sample(1'b1, 1'b0, 1'b1, 1'b1, $urandom));
      send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b1, $urandom));
      send_sample(pixel_sample(1'b0, 1'b0, 1'b1, 1'b0, $urandom));
      send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b1, $urandom));
      send_sample(pixel_sample(1'b0, 1'b0, 1'b1, 1'b0, $urandom));
      send_sample(pixel_sample(1'b1, 1'b0, 1'b0, 1'b0, $urandom));
      repeat (4) send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, $urandom));
      send_sample(pixel_sample(1'b0, 1'b0, 1'b1, 1'b1, $urandom));
      send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, $urandom));
      send_sample(pixel_sample(1'b0, 1'b1, 1'b1, 1'b0, $urandom));
      send_sample(pixel_sample(1'b0, 1'b1, 1'b0, 1'b0, $urandom));
      send_sample(pixel_sample(1'b0, 1'b0, 1'b0, 1'b0, $urandom));

      run_long_line();

      // Edge settings first: zero sizes with the unused rotate code, oversize
      // frames, a single line, a single column.
      run_phase(12'd0, 12'd0, ROT_UNUSED, 1'b1);
      run_phase(12'd4095, 12'd2049, ROT_LEFT, 1'b0);
      idle_on = 1'b0;
      run_phase(12'd2048, 12'd1, ROT_RIGHT, 1'b1);
      idle_on = 1'b1;
      run_phase(12'd1, 12'd2048, ROT_NONE, 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++)
         run_phase(pick_dim(), pick_dim(), ROT_W'($urandom_range(3)),
                   1'($urandom_range(1)));

      // Let the pipeline empty, then give stray writes a chance to show up.
      drain_writes();
      repeat (10) @(negedge clock);

      if (tracker.final_count() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
